@@ hdl/kdm_pkg.sv @@
// Shared types, constants and the keyword automaton transition function.
`default_nettype none
package kdm_pkg;

	localparam int unsigned STATE_BITS = 6;
	localparam int unsigned WORD_BITS  = 3;
	localparam int unsigned FIELD_BITS = 16;
	localparam int unsigned NUM_WORDS  = 6;
	localparam logic [STATE_BITS-1:0] LAST_STATE = 6'd34;

	typedef logic [STATE_BITS-1:0] state_t;

	typedef enum logic [WORD_BITS-1:0] {
		W_ESCUELA     = 3'd0,
		W_ESTUDIANTES = 3'd1,
		W_RENCOR      = 3'd2,
		W_RIFLES      = 3'd3,
		W_CRIMEN      = 3'd4,
		W_MATANZA     = 3'd5,
		W_NONE        = 3'd7
	} word_t;

	typedef struct packed {
		state_t next;
		word_t  word;
	} trans_t;

	typedef struct packed {
		logic  found;
		word_t word;
	} hit_t;

	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CASE_GAP   = 8'h20;

	function automatic logic [7:0] fold(input logic [7:0] ch);
		logic [7:0] r;
		r = ch;
		if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
			r = ch + CASE_GAP;
		end
		return r;
	endfunction

	function automatic state_t fallback(input logic [7:0] ch);
		state_t r;
		case (ch)
			"e": r = 6'd1;
			"c": r = 6'd21;
			"r": r = 6'd14;
			"m": r = 6'd26;
			default: r = 6'd0;
		endcase
		return r;
	endfunction

	function automatic trans_t step(input state_t s, input logic [7:0] ch);
		trans_t t;
		t.next = fallback(ch);
		t.word = W_NONE;
		if (s > LAST_STATE) begin
			t.next = s;
		end else begin
			case (s)
				6'd1:  if (ch == "s") t.next = 6'd2;
				6'd2: begin
					if (ch == "c") t.next = 6'd3;
					else if (ch == "t") t.next = 6'd7;
				end
				6'd3: begin
					if (ch == "u") t.next = 6'd4;
					else if (ch == "r") t.next = 6'd22;
				end
				6'd4:  if (ch == "e") t.next = 6'd5;
				6'd5: begin
					if (ch == "s") t.next = 6'd2;
					else if (ch == "l") t.next = 6'd6;
				end
				6'd6: begin
					if (ch == "a") begin
						t.next = 6'd0;
						t.word = W_ESCUELA;
					end
				end
				6'd7:  if (ch == "u") t.next = 6'd8;
				6'd8:  if (ch == "d") t.next = 6'd9;
				6'd9:  if (ch == "i") t.next = 6'd10;
				6'd10: if (ch == "a") t.next = 6'd11;
				6'd11: if (ch == "n") t.next = 6'd12;
				6'd12: if (ch == "t") t.next = 6'd13;
				6'd13: if (ch == "e") t.next = 6'd32;
				6'd32: begin
					if (ch == "s") begin
						t.next = 6'd2;
						t.word = W_ESTUDIANTES;
					end
				end
				6'd14: begin
					if (ch == "e") t.next = 6'd15;
					else if (ch == "i") t.next = 6'd19;
				end
				6'd15: begin
					if (ch == "s") t.next = 6'd2;
					else if (ch == "n") t.next = 6'd16;
				end
				6'd16: if (ch == "c") t.next = 6'd17;
				6'd17: begin
					if (ch == "r") t.next = 6'd22;
					else if (ch == "o") t.next = 6'd18;
				end
				6'd18: begin
					if (ch == "r") begin
						t.next = 6'd14;
						t.word = W_RENCOR;
					end
				end
				6'd19: if (ch == "f") t.next = 6'd20;
				6'd20: if (ch == "l") t.next = 6'd33;
				6'd33: if (ch == "e") t.next = 6'd34;
				6'd34: begin
					if (ch == "s") begin
						t.next = 6'd2;
						t.word = W_RIFLES;
					end
				end
				6'd21: if (ch == "r") t.next = 6'd22;
				6'd22: begin
					if (ch == "e") t.next = 6'd15;
					else if (ch == "i") t.next = 6'd23;
				end
				6'd23: begin
					if (ch == "f") t.next = 6'd20;
					else if (ch == "m") t.next = 6'd24;
				end
				6'd24: begin
					if (ch == "e") t.next = 6'd25;
					else if (ch == "a") t.next = 6'd27;
				end
				6'd25: begin
					if (ch == "s") begin
						t.next = 6'd2;
					end else if (ch == "n") begin
						t.next = 6'd0;
						t.word = W_CRIMEN;
					end
				end
				6'd26: if (ch == "a") t.next = 6'd27;
				6'd27: if (ch == "t") t.next = 6'd28;
				6'd28: if (ch == "a") t.next = 6'd29;
				6'd29: if (ch == "n") t.next = 6'd30;
				6'd30: if (ch == "z") t.next = 6'd31;
				6'd31: begin
					if (ch == "a") begin
						t.next = 6'd0;
						t.word = W_MATANZA;
					end
				end
				default: t.next = fallback(ch);
			endcase
		end
		return t;
	endfunction

endpackage
`default_nettype wire

@@ hdl/kdm_byte_if.sv @@
// Valid/ready channel carrying one text byte per request.
`default_nettype none
interface kdm_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;

	modport source (output valid, output text_byte, input ready);
	modport sink (input valid, input text_byte, output ready);
endinterface
`default_nettype wire

@@ hdl/kdm_match_if.sv @@
// Valid/ready channel carrying one match report per request.
`default_nettype none
interface kdm_match_if;
	logic        valid;
	logic        ready;
	logic        match_found;
	logic [2:0]  word_id;
	logic [15:0] line_number;
	logic [15:0] column_number;
	logic [15:0] word_total;

	modport source (
		output valid, output match_found, output word_id, output line_number,
		output column_number, output word_total, input ready
	);
	modport sink (
		input valid, input match_found, input word_id, input line_number,
		input column_number, input word_total, output ready
	);
endinterface
`default_nettype wire

@@ hdl/kdm_scan.sv @@
// Case folding, line/column tracking and automaton state register.
`default_nettype none
module kdm_scan #(
	parameter int unsigned POSITION_BITS = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     take,
	input  wire logic [7:0]               text_byte,
	output kdm_pkg::hit_t                 hit,
	output logic      [POSITION_BITS-1:0] line_next,
	output logic      [POSITION_BITS-1:0] col_next
);

	kdm_pkg::state_t               state_q;
	logic [POSITION_BITS-1:0]      line_q;
	logic [POSITION_BITS-1:0]      col_q;
	logic [7:0]                    ch;
	kdm_pkg::trans_t               tr;

	always_comb begin
		ch = kdm_pkg::fold(text_byte);
		tr = kdm_pkg::step(state_q, ch);
		hit.found = (tr.word != kdm_pkg::W_NONE);
		hit.word  = tr.word;
		line_next = line_q;
		col_next  = col_q;
		if (ch == kdm_pkg::CH_NEWLINE) begin
			col_next = '0;
			if (line_q != '1) line_next = line_q + 1'b1;
		end else begin
			if (col_q != '1) col_next = col_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			line_q  <= '0;
			col_q   <= '0;
		end else if (take) begin
			state_q <= tr.next;
			line_q  <= line_next;
			col_q   <= col_next;
		end
	end

endmodule
`default_nettype wire

@@ hdl/kdm_count_mem.sv @@
// Per-keyword match count memory with registered read and write-to-read bypass.
`default_nettype none
module kdm_count_mem #(
	parameter int unsigned COUNT_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  rd_en,
	input  wire logic [2:0]            rd_word,
	input  wire logic                  wr_en,
	input  wire logic [2:0]            wr_word,
	input  wire logic [COUNT_BITS-1:0] wr_data,
	output logic      [COUNT_BITS-1:0] rd_data
);

	logic [COUNT_BITS-1:0]         mem [kdm_pkg::NUM_WORDS];
	logic [kdm_pkg::NUM_WORDS-1:0] vld_q;
	logic [COUNT_BITS-1:0]         mem_rd_q;
	logic [COUNT_BITS-1:0]         fwd_data_q;
	logic                          fwd_q;
	logic                          hit_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_word] <= wr_data;
		if (rd_en) begin
			mem_rd_q   <= mem[rd_word];
			fwd_data_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			fwd_q     <= 1'b0;
			hit_vld_q <= 1'b0;
		end else begin
			if (wr_en) vld_q[wr_word] <= 1'b1;
			if (rd_en) begin
				fwd_q     <= wr_en && (wr_word == rd_word);
				hit_vld_q <= vld_q[rd_word];
			end
		end
	end

	assign rd_data = fwd_q ? fwd_data_q : (hit_vld_q ? mem_rd_q : '0);

endmodule
`default_nettype wire

@@ hdl/keyword_dfa_matcher_top.sv @@
// Keyword matcher top level: byte scan, count update stage and output register.
//
// Channel text carries one byte per request; channel result returns exactly
// one report per byte, in order. A report flags whether the byte completes
// one of six keywords, and gives its word id, the line and column after the
// byte, and the keyword's match total after this match.
// A taken byte passes the count stage register, then the output register, to
// its report. One byte is taken every cycle unless result stalls: automaton
// step and position update are registered as a byte is taken, its count is read
// then and written back as the count stage advances, with same-keyword bypass.
// Reset clears the automaton to its start state, zeroes line and column, and
// marks all counts as zero without a clearing pass, so bytes are taken at once.
// When result stalls, the report holds in its output register, one more byte
// waits in the count stage, and text.ready then drops until result is taken.
// Line, column and counts saturate at their register widths.
`default_nettype none
module keyword_dfa_matcher_top #(
	parameter int unsigned POSITION_BITS = 16,
	parameter int unsigned COUNT_BITS    = 16
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	kdm_byte_if.sink    text,
	kdm_match_if.source result
);

	logic                     take;
	logic                     advance;
	kdm_pkg::hit_t            hit;
	logic [POSITION_BITS-1:0] line_next;
	logic [POSITION_BITS-1:0] col_next;

	logic                     valid_s1;
	kdm_pkg::hit_t            hit_s1;
	logic [POSITION_BITS-1:0] line_s1;
	logic [POSITION_BITS-1:0] col_s1;

	logic [COUNT_BITS-1:0]    cnt_rd;
	logic [COUNT_BITS-1:0]    cnt_inc;
	logic                     cnt_wr;

	logic                     out_valid_q;
	logic                     out_found_q;
	logic [2:0]               out_word_q;
	logic [15:0]              out_line_q;
	logic [15:0]              out_col_q;
	logic [15:0]              out_total_q;

	assign advance    = !out_valid_q || result.ready;
	assign text.ready = !valid_s1 || advance;
	assign take       = text.valid && text.ready;
	assign cnt_inc    = (cnt_rd == '1) ? cnt_rd : cnt_rd + 1'b1;
	assign cnt_wr     = valid_s1 && advance && hit_s1.found;

	kdm_scan #(
		.POSITION_BITS(POSITION_BITS)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.text_byte (text.text_byte),
		.hit       (hit),
		.line_next (line_next),
		.col_next  (col_next)
	);

	kdm_count_mem #(
		.COUNT_BITS(COUNT_BITS)
	) u_count_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (take && hit.found),
		.rd_word (hit.word),
		.wr_en   (cnt_wr),
		.wr_word (hit_s1.word),
		.wr_data (cnt_inc),
		.rd_data (cnt_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) valid_s1 <= 1'b1;
			else if (advance) valid_s1 <= 1'b0;
			if (advance) out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			hit_s1  <= hit;
			line_s1 <= line_next;
			col_s1  <= col_next;
		end
		if (advance && valid_s1) begin
			out_found_q <= hit_s1.found;
			out_word_q  <= hit_s1.found ? hit_s1.word : 3'd0;
			out_line_q  <= 16'(line_s1);
			out_col_q   <= 16'(col_s1);
			out_total_q <= hit_s1.found ? 16'(cnt_inc) : 16'd0;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.match_found   = out_found_q;
	assign result.word_id       = out_word_q;
	assign result.line_number   = out_line_q;
	assign result.column_number = out_col_q;
	assign result.word_total    = out_total_q;

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking bench for the keyword matcher: opening byte table, random text, back-to-back tail.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic        found;
		logic [2:0]  word;
		logic [15:0] line;
		logic [15:0] col;
		logic [15:0] total;
	} report_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       typed;
		report_t    rep;
	} row_t;

	logic clk;
	logic arst_n;

	kdm_byte_if  text_bus ();
	kdm_match_if report_bus ();

	keyword_dfa_matcher_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.text(text_bus),
		.result(report_bus)
	);

	kdm_pkg::state_t scan_state;
	logic [15:0]     cur_line;
	logic [15:0]     cur_col;
	logic [15:0]     word_hits [kdm_pkg::NUM_WORDS];
	report_t         reports_due [$];
	row_t            opening_rows [$];
	int              mismatches;
	int              sent_count;
	bit              idle_on;
	bit              long_hold;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic logic [15:0] bump(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	// {word, next state} for one folded byte
	function automatic logic [8:0] dfa_arc(input kdm_pkg::state_t s, input logic [7:0] c);
		logic [8:0] r;
		case (c)
			"e": r = {kdm_pkg::W_NONE, 6'd1};
			"c": r = {kdm_pkg::W_NONE, 6'd21};
			"r": r = {kdm_pkg::W_NONE, 6'd14};
			"m": r = {kdm_pkg::W_NONE, 6'd26};
			default: r = {kdm_pkg::W_NONE, 6'd0};
		endcase
		if (s > kdm_pkg::LAST_STATE) begin
			return {kdm_pkg::W_NONE, s};
		end
		case ({s, c})
			{6'd1, "s"}, {6'd5, "s"}, {6'd15, "s"}, {6'd25, "s"}: r = {kdm_pkg::W_NONE, 6'd2};
			{6'd32, "s"}: r = {kdm_pkg::W_ESTUDIANTES, 6'd2};
			{6'd34, "s"}: r = {kdm_pkg::W_RIFLES, 6'd2};
			{6'd2, "c"}: r = {kdm_pkg::W_NONE, 6'd3};
			{6'd3, "u"}: r = {kdm_pkg::W_NONE, 6'd4};
			{6'd4, "e"}: r = {kdm_pkg::W_NONE, 6'd5};
			{6'd5, "l"}: r = {kdm_pkg::W_NONE, 6'd6};
			{6'd6, "a"}: r = {kdm_pkg::W_ESCUELA, 6'd0};
			{6'd2, "t"}: r = {kdm_pkg::W_NONE, 6'd7};
			{6'd7, "u"}: r = {kdm_pkg::W_NONE, 6'd8};
			{6'd8, "d"}: r = {kdm_pkg::W_NONE, 6'd9};
			{6'd9, "i"}: r = {kdm_pkg::W_NONE, 6'd10};
			{6'd10, "a"}: r = {kdm_pkg::W_NONE, 6'd11};
			{6'd11, "n"}: r = {kdm_pkg::W_NONE, 6'd12};
			{6'd12, "t"}: r = {kdm_pkg::W_NONE, 6'd13};
			{6'd13, "e"}: r = {kdm_pkg::W_NONE, 6'd32};
			{6'd14, "e"}, {6'd22, "e"}: r = {kdm_pkg::W_NONE, 6'd15};
			{6'd14, "i"}: r = {kdm_pkg::W_NONE, 6'd19};
			{6'd15, "n"}: r = {kdm_pkg::W_NONE, 6'd16};
			{6'd16, "c"}: r = {kdm_pkg::W_NONE, 6'd17};
			{6'd3, "r"}, {6'd17, "r"}, {6'd21, "r"}: r = {kdm_pkg::W_NONE, 6'd22};
			{6'd17, "o"}: r = {kdm_pkg::W_NONE, 6'd18};
			{6'd18, "r"}: r = {kdm_pkg::W_RENCOR, 6'd14};
			{6'd19, "f"}, {6'd23, "f"}: r = {kdm_pkg::W_NONE, 6'd20};
			{6'd20, "l"}: r = {kdm_pkg::W_NONE, 6'd33};
			{6'd33, "e"}: r = {kdm_pkg::W_NONE, 6'd34};
			{6'd22, "i"}: r = {kdm_pkg::W_NONE, 6'd23};
			{6'd23, "m"}: r = {kdm_pkg::W_NONE, 6'd24};
			{6'd24, "e"}: r = {kdm_pkg::W_NONE, 6'd25};
			{6'd24, "a"}, {6'd26, "a"}: r = {kdm_pkg::W_NONE, 6'd27};
			{6'd25, "n"}: r = {kdm_pkg::W_CRIMEN, 6'd0};
			{6'd27, "t"}: r = {kdm_pkg::W_NONE, 6'd28};
			{6'd28, "a"}: r = {kdm_pkg::W_NONE, 6'd29};
			{6'd29, "n"}: r = {kdm_pkg::W_NONE, 6'd30};
			{6'd30, "z"}: r = {kdm_pkg::W_NONE, 6'd31};
			{6'd31, "a"}: r = {kdm_pkg::W_MATANZA, 6'd0};
			default: ;
		endcase
		return r;
	endfunction

	function automatic report_t scan_byte(input logic [7:0] raw);
		logic [7:0] c;
		logic [8:0] arc;
		logic [2:0] w;
		report_t    rep;
		c = raw;
		if (c >= kdm_pkg::CH_UPPER_A && c <= kdm_pkg::CH_UPPER_Z) begin
			c = c + kdm_pkg::CASE_GAP;
		end
		if (c == kdm_pkg::CH_NEWLINE) begin
			cur_col = 16'd0;
			cur_line = bump(cur_line);
		end else begin
			cur_col = bump(cur_col);
		end
		arc = dfa_arc(scan_state, c);
		scan_state = arc[5:0];
		w = arc[8:6];
		rep = '0;
		rep.line = cur_line;
		rep.col = cur_col;
		if (w != kdm_pkg::W_NONE) begin
			word_hits[w] = bump(word_hits[w]);
			rep.found = 1'b1;
			rep.word = w;
			rep.total = word_hits[w];
		end
		return rep;
	endfunction

	function automatic string phrase(input int k);
		case (k)
			0: return "escuela";
			1: return "estudiantes";
			2: return "rencor";
			3: return "rifles";
			4: return "crimen";
			5: return "matanza";
			6: return "escrimen";
			7: return "rencorencor";
			8: return "riflestudiantes";
			9: return "estudiantescuela";
			10: return "crimatanza";
			11: return "escuescuela";
			12: return "crimestudiantes";
			default: return "rencrifles";
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic use_given, input report_t given);
		report_t rep;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			text_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		text_bus.valid <= 1'b1;
		text_bus.text_byte <= b;
		@(posedge clk);
		while (!text_bus.ready) @(posedge clk);
		rep = scan_byte(b);
		reports_due.push_back(use_given ? given : rep);
		sent_count++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s, input bit mixed);
		logic [7:0] c;
		for (int i = 0; i < s.len(); i++) begin
			c = s[i];
			if (mixed && $urandom_range(0, 1) == 1) begin
				c = c - kdm_pkg::CASE_GAP;
			end
			send_byte(c, 1'b0, '0);
		end
	endtask

	task automatic drain();
		text_bus.valid <= 1'b0;
		while (reports_due.size() != 0) @(negedge clk);
	endtask

	initial begin
		report_bus.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				report_bus.ready <= 1'b0;
				repeat (200) @(negedge clk);
				long_hold = 1'b0;
				report_bus.ready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				report_bus.ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(negedge clk);
				report_bus.ready <= 1'b1;
			end else begin
				report_bus.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_reports
		report_t got;
		report_t want;
		if (arst_n && report_bus.valid && report_bus.ready) begin
			got = {report_bus.match_found, report_bus.word_id, report_bus.line_number,
				report_bus.column_number, report_bus.word_total};
			if (reports_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: report with none due: found=%0d word=%0d",
						$realtime, got.found, got.word);
					$display("%0t:   line=%0d col=%0d total=%0d",
						$realtime, got.line, got.col, got.total);
				end
			end else begin
				want = reports_due.pop_front();
				if (got.found !== want.found || got.word !== want.word || got.line !== want.line ||
						got.col !== want.col || got.total !== want.total) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: expected found=%0d word=%0d line=%0d col=%0d total=%0d",
							$realtime, want.found, want.word, want.line, want.col, want.total);
						$display("%0t:   actual found=%0d word=%0d line=%0d col=%0d total=%0d",
							$realtime, got.found, got.word, got.line, got.col, got.total);
					end
				end
			end
		end
	end

	initial begin : stimulus
		row_t       row;
		logic [7:0] c;
		string      letters;
		int         base;
		int         pick;
		letters = "escuelatdinrofmzx";
		arst_n = 1'b0;
		text_bus.valid = 1'b0;
		text_bus.text_byte = 8'h00;
		idle_on = 1'b1;
		long_hold = 1'b0;
		mismatches = 0;
		sent_count = 0;
		scan_state = '0;
		cur_line = 16'd0;
		cur_col = 16'd0;
		for (int i = 0; i < kdm_pkg::NUM_WORDS; i++) begin
			word_hits[i] = 16'd0;
		end

		opening_rows.push_back({8'h00, 1'b1, 1'b0, kdm_pkg::W_ESCUELA, 16'd0, 16'd1, 16'd0});
		opening_rows.push_back({8'hFF, 1'b1, 1'b0, kdm_pkg::W_ESCUELA, 16'd0, 16'd2, 16'd0});
		opening_rows.push_back({kdm_pkg::CH_NEWLINE, 1'b1, 1'b0, kdm_pkg::W_ESCUELA,
			16'd1, 16'd0, 16'd0});
		opening_rows.push_back({"@", 1'b0, 52'd0});
		opening_rows.push_back({"[", 1'b0, 52'd0});
		opening_rows.push_back({"E", 1'b0, 52'd0});
		opening_rows.push_back({"s", 1'b0, 52'd0});
		opening_rows.push_back({"C", 1'b0, 52'd0});
		opening_rows.push_back({"u", 1'b0, 52'd0});
		opening_rows.push_back({"E", 1'b0, 52'd0});
		opening_rows.push_back({"l", 1'b0, 52'd0});
		opening_rows.push_back({"A", 1'b1, 1'b1, kdm_pkg::W_ESCUELA, 16'd1, 16'd9, 16'd1});
		opening_rows.push_back({"r", 1'b0, 52'd0});
		opening_rows.push_back({"E", 1'b0, 52'd0});
		opening_rows.push_back({"N", 1'b0, 52'd0});
		opening_rows.push_back({"C", 1'b0, 52'd0});
		opening_rows.push_back({"O", 1'b0, 52'd0});
		opening_rows.push_back({"R", 1'b1, 1'b1, kdm_pkg::W_RENCOR, 16'd1, 16'd15, 16'd1});
		opening_rows.push_back({"e", 1'b0, 52'd0});
		opening_rows.push_back({"n", 1'b0, 52'd0});
		opening_rows.push_back({"c", 1'b0, 52'd0});
		opening_rows.push_back({"o", 1'b0, 52'd0});
		opening_rows.push_back({"R", 1'b1, 1'b1, kdm_pkg::W_RENCOR, 16'd1, 16'd20, 16'd2});

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (opening_rows[i]) begin
			row = opening_rows[i];
			send_byte(row.ch, row.typed, row.rep);
		end

		// hold off the report side while requests keep coming
		long_hold = 1'b1;
		repeat (40) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
		drain();

		base = sent_count;
		while (sent_count - base < 1000) begin
			idle_on = (((sent_count - base) / 150) % 3) != 2;
			pick = $urandom_range(0, 19);
			if (pick < 12) begin
				send_text(phrase($urandom_range(0, 13)), 1'b1);
			end else if (pick < 16) begin
				repeat ($urandom_range(1, 4)) begin
					c = letters[$urandom_range(0, letters.len() - 1)];
					if ($urandom_range(0, 1) == 1) begin
						c = c - kdm_pkg::CASE_GAP;
					end
					send_byte(c, 1'b0, '0);
				end
			end else if (pick < 18) begin
				send_byte(kdm_pkg::CH_NEWLINE, 1'b0, '0);
			end else begin
				send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
			end
		end
		drain();

		// chain overlapping matches back to back
		idle_on = 1'b0;
		send_byte(kdm_pkg::CH_NEWLINE, 1'b0, '0);
		send_text("rencor", 1'b0);
		repeat (6) send_text("encor", 1'b0);
		send_text("matanza", 1'b1);
		text_bus.valid <= 1'b0;
		drain();
		repeat (8) @(posedge clk);

		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ keyword_dfa_matcher_top.f @@
hdl/kdm_pkg.sv
hdl/kdm_byte_if.sv
hdl/kdm_match_if.sv
hdl/kdm_scan.sv
hdl/kdm_count_mem.sv
hdl/keyword_dfa_matcher_top.sv
verif/tb_top.sv
